// File: rtl/lfps_pkg.sv
// Shared types and constants for the line-following PID steering block.
// Holds the request payloads, the register set, the controller command word
// and the fixed sensor weights. No dependencies.
package lfps_pkg;

	// Field and arithmetic widths fixed by the interface.
	localparam int unsigned SENSORS_MAX = 8;
	localparam int unsigned ERR_W       = 12;
	localparam int unsigned SPEED_W     = 15;
	localparam int unsigned GAIN_W      = 16;
	localparam int unsigned INTEG_W     = 16;
	localparam int unsigned LIMIT_W     = 48;

	// The divider produces one quotient bit per cycle.
	localparam int unsigned QUOT_W    = 12;
	localparam int unsigned DIV_STEPS = QUOT_W;
	localparam int unsigned CNT_W     = 4;

	// APB register port.
	localparam int unsigned APB_ADDR_W = 6;
	localparam int unsigned APB_DATA_W = 64;

	// Register indexes; each register sits at eight times its index.
	typedef enum logic [2:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_NOMINAL_DRIVE,
		REG_DRIVE_CAP,
		REG_STEER_LIMIT,
		REG_INTEG_LIMITS
	} reg_idx_t;

	// Error thresholds in Q8.8: deadband 0.6, medium 1.5, large 3.0.
	localparam logic [ERR_W-1:0] DEADBAND   = 12'd154;
	localparam logic [ERR_W-1:0] ERR_MEDIUM = 12'd384;
	localparam logic [ERR_W-1:0] ERR_LARGE  = 12'd768;

	// Position weight of each sensor, left to right.
	localparam logic signed [3:0] WEIGHTS [SENSORS_MAX] = '{
		-4'sd5, -4'sd4, -4'sd2, -4'sd1, 4'sd1, 4'sd2, 4'sd4, 4'sd5
	};

	typedef struct packed {
		logic [SENSORS_MAX-1:0] sensor_bits;
	} sensor_req_t;

	typedef struct packed {
		logic [SPEED_W-1:0]      left_drive;
		logic [SPEED_W-1:0]      right_drive;
		logic signed [ERR_W-1:0] error_out;
	} wheel_req_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  gain_p;
		logic [GAIN_W-1:0]  gain_i;
		logic [GAIN_W-1:0]  gain_d;
		logic [SPEED_W-1:0] nominal_drive;
		logic [SPEED_W-1:0] drive_cap;
		logic [SPEED_W-1:0] steer_limit;
		logic [LIMIT_W-1:0] integral_limits;
	} cfg_t;

	// Operand pair for the shared multiplier.
	typedef enum logic [1:0] {
		MUL_GP,
		MUL_GI,
		MUL_GD
	} mul_sel_t;

	// Accumulator operation for the PID sum.
	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD_SHIFT,
		ACC_ADD
	} acc_op_t;

	typedef struct packed {
		logic     start;
		logic     div_step;
		logic     err_step;
		logic     integ_step;
		logic     mul_en;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     steer_step;
		logic     out_load;
	} cmd_t;

endpackage

// File: rtl/lfps_stream_if.sv
// Valid/ready channel carrying one request payload.
// The payload type is set per instance; no other dependencies.
interface lfps_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/lfps_cfg_regs.sv
// APB register file for gains, speeds, steering clamp and integral limits.
// Depends on lfps_pkg for the register struct and port widths.
module lfps_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [lfps_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [lfps_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [lfps_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready,
	output lfps_pkg::cfg_t                       cfg
);
	lfps_pkg::cfg_t     cfg_q;
	lfps_pkg::reg_idx_t reg_idx;
	logic               wr_en;

	// Registers sit on 8-byte boundaries.
	assign reg_idx = lfps_pkg::reg_idx_t'(paddr[5:3]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// Register writes on the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				lfps_pkg::REG_GAIN_P:        cfg_q.gain_p          <= pwdata[15:0];
				lfps_pkg::REG_GAIN_I:        cfg_q.gain_i          <= pwdata[15:0];
				lfps_pkg::REG_GAIN_D:        cfg_q.gain_d          <= pwdata[15:0];
				lfps_pkg::REG_NOMINAL_DRIVE: cfg_q.nominal_drive   <= pwdata[14:0];
				lfps_pkg::REG_DRIVE_CAP:     cfg_q.drive_cap       <= pwdata[14:0];
				lfps_pkg::REG_STEER_LIMIT:   cfg_q.steer_limit     <= pwdata[14:0];
				lfps_pkg::REG_INTEG_LIMITS:  cfg_q.integral_limits <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	// Read-back multiplexer; unused addresses read as zero.
	always_comb begin
		unique case (reg_idx)
			lfps_pkg::REG_GAIN_P:        prdata = 64'(cfg_q.gain_p);
			lfps_pkg::REG_GAIN_I:        prdata = 64'(cfg_q.gain_i);
			lfps_pkg::REG_GAIN_D:        prdata = 64'(cfg_q.gain_d);
			lfps_pkg::REG_NOMINAL_DRIVE: prdata = 64'(cfg_q.nominal_drive);
			lfps_pkg::REG_DRIVE_CAP:     prdata = 64'(cfg_q.drive_cap);
			lfps_pkg::REG_STEER_LIMIT:   prdata = 64'(cfg_q.steer_limit);
			lfps_pkg::REG_INTEG_LIMITS:  prdata = 64'(cfg_q.integral_limits);
			default:                     prdata = '0;
		endcase
	end

endmodule

// File: rtl/lfps_ctrl.sv
// Sequencer for the steering datapath: divider steps, error and integral
// update, three passes of the shared multiplier, clamps and output load.
// Depends on lfps_pkg for the command word.
module lfps_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output lfps_pkg::cmd_t cmd
);
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_ERROR,
		ST_INTEG,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_ACCUM,
		ST_STEER,
		ST_WHEEL
	} state_t;

	state_t                     state_q;
	logic [lfps_pkg::CNT_W-1:0] cnt_q;
	logic                       out_valid_q;
	logic                       slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	// Commands decoded from the current state.
	always_comb begin
		cmd         = '0;
		cmd.mul_sel = lfps_pkg::MUL_GP;
		cmd.acc_op  = lfps_pkg::ACC_HOLD;
		unique case (state_q)
			ST_IDLE:   cmd.start = in_valid;
			ST_DIVIDE: cmd.div_step = 1'b1;
			ST_ERROR:  cmd.err_step = 1'b1;
			ST_INTEG:  cmd.integ_step = 1'b1;
			ST_MUL_P: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = lfps_pkg::MUL_GP;
			end
			ST_MUL_I: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = lfps_pkg::MUL_GI;
				cmd.acc_op  = lfps_pkg::ACC_LOAD;
			end
			ST_MUL_D: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = lfps_pkg::MUL_GD;
				cmd.acc_op  = lfps_pkg::ACC_ADD_SHIFT;
			end
			ST_ACCUM:  cmd.acc_op = lfps_pkg::ACC_ADD;
			ST_STEER:  cmd.steer_step = 1'b1;
			ST_WHEEL:  cmd.out_load = slot_free;
			default: ;
		endcase
	end

	// State, divider count and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.out_load || (out_valid_q && !out_ready);
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_valid) begin
						state_q <= ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == lfps_pkg::CNT_W'(lfps_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_ERROR;
					end
				end
				ST_ERROR: state_q <= ST_INTEG;
				ST_INTEG: state_q <= ST_MUL_P;
				ST_MUL_P: state_q <= ST_MUL_I;
				ST_MUL_I: state_q <= ST_MUL_D;
				ST_MUL_D: state_q <= ST_ACCUM;
				ST_ACCUM: state_q <= ST_STEER;
				ST_STEER: state_q <= ST_WHEEL;
				ST_WHEEL: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/lfps_datapath.sv
// Steering datapath: weighted sensor mean through a bit-serial divider,
// deadband and integral update, shared multiplier PID sum and wheel clamps.
// Depends on lfps_pkg for types, weights and thresholds.
module lfps_datapath #(
	parameter int unsigned SENSOR_COUNT = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lfps_pkg::cmd_t        cmd,
	input  lfps_pkg::cfg_t        cfg,
	input  lfps_pkg::sensor_req_t sensor_req,
	output lfps_pkg::wheel_req_t  wheel_req
);
	// Weight sum and count over the fitted sensors.
	logic signed [4:0] wsum;
	logic [3:0]        wcnt;
	logic [3:0]        wabs;

	always_comb begin
		wsum = '0;
		wcnt = '0;
		for (int i = 0; i < lfps_pkg::SENSORS_MAX; i++) begin
			if (sensor_req.sensor_bits[i] && (i < SENSOR_COUNT)) begin
				wsum = wsum + 5'(lfps_pkg::WEIGHTS[i]);
				wcnt = wcnt + 4'd1;
			end
		end
		wabs = wsum[4] ? 4'(-wsum) : wsum[3:0];
	end

	// Restoring divider, one quotient bit per step.
	logic [lfps_pkg::QUOT_W-1:0] dividend_q;
	logic [lfps_pkg::QUOT_W-1:0] quot_q;
	logic [3:0]                  divisor_q;
	logic [2:0]                  rem_q;
	logic                        neg_q;
	logic                        found_q;
	logic [3:0]                  trial;
	logic                        trial_ge;

	assign trial    = {rem_q, dividend_q[lfps_pkg::QUOT_W-1]};
	assign trial_ge = (trial >= divisor_q);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dividend_q <= {wabs, 8'h00};
			divisor_q  <= wcnt;
			neg_q      <= wsum[4];
			found_q    <= (wcnt != 4'd0);
			rem_q      <= '0;
			quot_q     <= '0;
		end else if (cmd.div_step) begin
			dividend_q <= {dividend_q[lfps_pkg::QUOT_W-2:0], 1'b0};
			quot_q     <= {quot_q[lfps_pkg::QUOT_W-2:0], trial_ge};
			if (trial_ge) begin
				rem_q <= 3'(trial - divisor_q);
			end else begin
				rem_q <= trial[2:0];
			end
		end
	end

	// Round half away from zero, fall back on the last error, apply deadband.
	logic signed [lfps_pkg::ERR_W-1:0] prev_error_q;
	logic signed [lfps_pkg::ERR_W-1:0] raw_q;
	logic signed [lfps_pkg::ERR_W-1:0] e_q;
	logic                              round_up;
	logic [lfps_pkg::QUOT_W-1:0]       quot_rnd;
	logic signed [lfps_pkg::ERR_W-1:0] mean;
	logic signed [lfps_pkg::ERR_W-1:0] raw;
	logic [lfps_pkg::ERR_W-1:0]        raw_mag;

	assign round_up = ({rem_q, 1'b0} >= divisor_q);
	assign quot_rnd = quot_q + lfps_pkg::QUOT_W'(round_up);
	assign mean     = neg_q ? $signed(-quot_rnd) : $signed(quot_rnd);
	assign raw      = found_q ? mean : prev_error_q;
	assign raw_mag  = raw[lfps_pkg::ERR_W-1] ? 12'(-raw) : raw;

	always_ff @(posedge clk) begin
		if (cmd.err_step) begin
			raw_q <= raw;
			e_q   <= (raw_mag < lfps_pkg::DEADBAND) ? '0 : raw;
		end
	end

	// Integral update: sign-change reset, truncation, limit by error size.
	logic signed [lfps_pkg::INTEG_W-1:0] integ_q;
	logic signed [12:0]                  de_q;
	logic [lfps_pkg::ERR_W-1:0]          e_mag;
	logic [15:0]                         lim16;
	logic                                flip;
	logic signed [lfps_pkg::INTEG_W-1:0] i_base;
	logic signed [24:0]                  ix;
	logic signed [16:0]                  itr;
	logic signed [17:0]                  it18;
	logic signed [17:0]                  lim_pos;
	logic signed [17:0]                  lim_neg;
	logic signed [17:0]                  iclamp;
	logic signed [lfps_pkg::INTEG_W-1:0] integ_new;

	always_comb begin
		e_mag = e_q[lfps_pkg::ERR_W-1] ? 12'(-e_q) : e_q;
		priority if (e_mag > lfps_pkg::ERR_LARGE) begin
			lim16 = cfg.integral_limits[47:32];
		end else if (e_mag > lfps_pkg::ERR_MEDIUM) begin
			lim16 = cfg.integral_limits[31:16];
		end else begin
			lim16 = cfg.integral_limits[15:0];
		end
		flip   = ((prev_error_q > 0) && (e_q < 0)) || ((prev_error_q < 0) && (e_q > 0));
		i_base = flip ? '0 : integ_q;
		ix     = 25'($signed({i_base, 8'h00})) + 25'(e_q);
		// Arithmetic shift floors; step up by one for a negative inexact value.
		itr    = 17'(ix >>> 8) + 17'(ix[24] && (ix[7:0] != 8'h00));
		it18   = 18'(itr);
		lim_pos = $signed({2'b00, lim16});
		lim_neg = -lim_pos;
		if (it18 > lim_pos) begin
			iclamp = lim_pos;
		end else if (it18 < lim_neg) begin
			iclamp = lim_neg;
		end else begin
			iclamp = it18;
		end
		if (iclamp > 18'sd32767) begin
			integ_new = 16'sh7FFF;
		end else if (iclamp < -18'sd32768) begin
			integ_new = 16'sh8000;
		end else begin
			integ_new = iclamp[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q      <= '0;
			prev_error_q <= '0;
		end else if (cmd.integ_step) begin
			integ_q      <= integ_new;
			prev_error_q <= e_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.integ_step) begin
			de_q <= 13'(e_q) - 13'(prev_error_q);
		end
	end

	// Shared multiplier: unsigned gain against a signed operand.
	logic signed [16:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [33:0] prod_q;
	logic signed [42:0] prod_ext;
	logic signed [42:0] acc_q;

	always_comb begin
		unique case (cmd.mul_sel)
			lfps_pkg::MUL_GP: begin
				mul_a = $signed({1'b0, cfg.gain_p});
				mul_b = 17'(e_q);
			end
			lfps_pkg::MUL_GI: begin
				mul_a = $signed({1'b0, cfg.gain_i});
				mul_b = 17'(integ_q);
			end
			lfps_pkg::MUL_GD: begin
				mul_a = $signed({1'b0, cfg.gain_d});
				mul_b = 17'(de_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_ext = 43'(prod_q);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// PID accumulator; the integral term carries an extra factor of 256.
	always_ff @(posedge clk) begin
		unique case (cmd.acc_op)
			lfps_pkg::ACC_HOLD:      acc_q <= acc_q;
			lfps_pkg::ACC_LOAD:      acc_q <= prod_ext;
			lfps_pkg::ACC_ADD_SHIFT: acc_q <= acc_q + (prod_ext <<< 8);
			lfps_pkg::ACC_ADD:       acc_q <= acc_q + prod_ext;
			default:                 acc_q <= acc_q;
		endcase
	end

	// Floor to Q8.8 and clamp to the steering limit.
	logic signed [34:0] steer_raw;
	logic signed [34:0] steer_lim;
	logic signed [23:0] steer_q;

	assign steer_raw = 35'(acc_q >>> 8);
	assign steer_lim = $signed({12'd0, cfg.steer_limit, 8'h00});

	always_ff @(posedge clk) begin
		if (cmd.steer_step) begin
			if (steer_raw > steer_lim) begin
				steer_q <= 24'(steer_lim);
			end else if (steer_raw < -steer_lim) begin
				steer_q <= 24'(-steer_lim);
			end else begin
				steer_q <= 24'(steer_raw);
			end
		end
	end

	// Wheel values: base plus or minus steering, clamped to 0..drive_cap.
	logic signed [24:0]           base_v;
	logic signed [24:0]           lv;
	logic signed [24:0]           rv;
	logic [15:0]                  ls16;
	logic [15:0]                  rs16;
	logic [lfps_pkg::SPEED_W-1:0] ls;
	logic [lfps_pkg::SPEED_W-1:0] rs;
	lfps_pkg::wheel_req_t         out_q;

	always_comb begin
		base_v = $signed({2'b00, cfg.nominal_drive, 8'h00});
		lv     = base_v + 25'(steer_q);
		rv     = base_v - 25'(steer_q);
		ls16   = lv[24] ? 16'd0 : lv[23:8];
		rs16   = rv[24] ? 16'd0 : rv[23:8];
		ls     = (ls16 > {1'b0, cfg.drive_cap}) ? cfg.drive_cap : ls16[14:0];
		rs     = (rs16 > {1'b0, cfg.drive_cap}) ? cfg.drive_cap : rs16[14:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.left_drive  <= ls;
			out_q.right_drive <= rs;
			out_q.error_out   <= raw_q;
		end
	end

	assign wheel_req = out_q;

endmodule

// File: rtl/line_follow_pid_steering.sv
// Top level of the line-following PID steering block.
// Depends on lfps_pkg, lfps_stream_if, lfps_cfg_regs, lfps_ctrl and lfps_datapath.
//
//  Channel     Direction  Payload                                 Handshake
//  sensor_in   in         sensor_bits[7:0]                        valid/ready
//  wheel_out   out        left_drive, right_drive, error_out      valid/ready
//  APB         in         gain, speed, steer and limit registers  psel/penable
//
// A request is taken when the block is idle and its result is valid once it
// has passed the bit-serial divider for the weighted mean, the error and
// integral steps, the shared multiplier and the steering and wheel clamps.
// A new request is taken the cycle after the result is loaded, while that result
// still waits in the output register. If the previous result is still held
// when the next is ready, the block stalls until the sink takes it.
// Reset clears the registers, the last error, the integral and all valid flags.
module line_follow_pid_steering #(
	parameter int unsigned SENSOR_COUNT = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	lfps_stream_if.sink                     sensor_in,
	lfps_stream_if.source                   wheel_out,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lfps_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [lfps_pkg::APB_DATA_W-1:0] pwdata,
	output logic [lfps_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);
	lfps_pkg::cfg_t        cfg;
	lfps_pkg::cmd_t        cmd;
	lfps_pkg::sensor_req_t sensor_req;
	lfps_pkg::wheel_req_t  wheel_req;
	logic                  in_ready;
	logic                  out_valid;

	// Register file.
	lfps_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer.
	lfps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sensor_in.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (wheel_out.ready),
		.cmd       (cmd)
	);

	// Arithmetic.
	lfps_datapath #(
		.SENSOR_COUNT (SENSOR_COUNT)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg),
		.sensor_req (sensor_req),
		.wheel_req  (wheel_req)
	);

	assign sensor_req        = sensor_in.payload;
	assign sensor_in.ready   = in_ready;
	assign wheel_out.valid   = out_valid;
	assign wheel_out.payload = wheel_req;

endmodule

// File: sim/tb_line_follow_pid_steering.sv
`timescale 1ns / 1ps
// Self-checking testbench for line_follow_pid_steering: sensor requests go in,
// wheel requests are checked against a cycle-free predictor of the controller.
// Depends on lfps_pkg, lfps_stream_if and the RTL of the block.
module tb_line_follow_pid_steering;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 7;
	localparam int PHASE_ITEMS  = 200;
	localparam int LIMIT_CYCLES = 400000;
	localparam int ADDR_W       = lfps_pkg::APB_ADDR_W;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Bus-side drive values, all known from time zero.
	logic                            in_valid = 1'b0;
	logic [7:0]                      in_bits = '0;
	logic                            out_ready = 1'b0;
	logic                            psel = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite = 1'b0;
	logic [ADDR_W-1:0]               paddr = '0;
	logic [lfps_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [lfps_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;

	lfps_stream_if #(.payload_t(lfps_pkg::sensor_req_t)) sensor_if ();
	lfps_stream_if #(.payload_t(lfps_pkg::wheel_req_t))  wheel_if ();

	assign sensor_if.valid   = in_valid;
	assign sensor_if.payload = in_bits;
	assign wheel_if.ready    = out_ready;

	line_follow_pid_steering #(
		.SENSOR_COUNT(8)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sensor_in(sensor_if),
		.wheel_out(wheel_if),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Predictor state: settings as last written, last error and integral.
	int                   line_weight [8] = '{-5, -4, -2, -1, 1, 2, 4, 5};
	lfps_pkg::cfg_t       model_cfg = '0;
	int                   prior_err = 0;
	int                   integral_acc = 0;

	logic [7:0]           pending_masks [$];
	lfps_pkg::wheel_req_t expected_wheels [$];
	int                   mismatches = 0;
	int                   sensors_accepted = 0;
	int                   wheels_checked = 0;
	int                   settings_used = 0;
	bit                   sensor_taken = 1'b0;
	bit                   idling_on = 1'b1;
	int                   send_gap_left = 0;
	int                   stall_left = 0;
	int                   hold_left = 0;
	bit                   hold_done = 1'b0;
	longint               cycle_count = 0;

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Works out the wheel request for one sensor request and advances the
	// controller state, exactly as the block should.
	function automatic lfps_pkg::wheel_req_t predict_wheels(input logic [7:0] bits);
		int                   idx;
		int                   weight_sum;
		int                   hits;
		int                   num;
		int                   quo;
		int                   rem;
		int                   raw;
		int                   err;
		int                   mag;
		int                   lim;
		longint               integ_next;
		longint               pid_acc;
		longint               steer;
		longint               steer_cap;
		longint               lv;
		longint               rv;
		longint               ls;
		longint               rs;
		lfps_pkg::wheel_req_t res;
		weight_sum = 0;
		hits = 0;
		for (idx = 0; idx < 8; idx++) begin
			if (bits[idx]) begin
				weight_sum += line_weight[idx];
				hits++;
			end
		end
		// Weighted mean in Q8.8 with halves rounded away from zero; a lost
		// line keeps the last error.
		if (hits == 0) begin
			raw = prior_err;
		end else begin
			num = weight_sum * 256;
			quo = (num < 0 ? -num : num) / hits;
			rem = (num < 0 ? -num : num) % hits;
			if (2 * rem >= hits) begin
				quo++;
			end
			raw = num < 0 ? -quo : quo;
		end
		err = (raw > -154 && raw < 154) ? 0 : raw;

		// A swing to the other side of the line empties the integral.
		if ((prior_err > 0 && err < 0) || (prior_err < 0 && err > 0)) begin
			integral_acc = 0;
		end
		mag = err < 0 ? -err : err;
		if (mag > 768) begin
			lim = int'(model_cfg.integral_limits[47:32]);
		end else if (mag > 384) begin
			lim = int'(model_cfg.integral_limits[31:16]);
		end else begin
			lim = int'(model_cfg.integral_limits[15:0]);
		end
		integ_next = (longint'(integral_acc) * 256 + err) / 256;
		if (integ_next > lim) begin
			integ_next = lim;
		end
		if (integ_next < -lim) begin
			integ_next = -lim;
		end
		if (integ_next > 32767) begin
			integ_next = 32767;
		end
		if (integ_next < -32768) begin
			integ_next = -32768;
		end
		integral_acc = int'(integ_next);

		// PID sum in Q16.16, floored to Q8.8 and clamped to the steering limit.
		pid_acc = longint'(model_cfg.gain_p) * err
			+ longint'(model_cfg.gain_i) * integral_acc * 256
			+ longint'(model_cfg.gain_d) * (err - prior_err);
		steer = pid_acc >>> 8;
		steer_cap = longint'(model_cfg.steer_limit) * 256;
		if (steer > steer_cap) begin
			steer = steer_cap;
		end
		if (steer < -steer_cap) begin
			steer = -steer_cap;
		end
		prior_err = err;

		// Wheel drive values, floored at zero and capped at the top speed.
		lv = longint'(model_cfg.nominal_drive) * 256 + steer;
		rv = longint'(model_cfg.nominal_drive) * 256 - steer;
		ls = lv < 0 ? 0 : lv >>> 8;
		rs = rv < 0 ? 0 : rv >>> 8;
		if (ls > model_cfg.drive_cap) begin
			ls = model_cfg.drive_cap;
		end
		if (rs > model_cfg.drive_cap) begin
			rs = model_cfg.drive_cap;
		end
		res.left_drive  = ls[lfps_pkg::SPEED_W-1:0];
		res.right_drive = rs[lfps_pkg::SPEED_W-1:0];
		res.error_out   = raw[lfps_pkg::ERR_W-1:0];
		return res;
	endfunction

	// Sensor driver: offers the next pending mask, with random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || sensor_taken) begin
			if (send_gap_left > 0) begin
				send_gap_left <= send_gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_masks.size() != 0) begin
				in_valid <= 1'b1;
				in_bits <= pending_masks.pop_front();
				if (idling_on && $urandom_range(0, 3) == 0) begin
					send_gap_left <= $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Wheel receiver: random stall bursts plus one long hold-off mid-run so
	// that the block backs up and refuses sensor requests.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (!hold_done && sensors_accepted >= 400) begin
			hold_done <= 1'b1;
			hold_left <= 160;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (idling_on && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 5);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Monitor: predicts on each accepted sensor request and checks each
	// accepted wheel request against the oldest prediction.
	always @(posedge clk) begin
		lfps_pkg::wheel_req_t want;
		lfps_pkg::wheel_req_t got;
		sensor_taken = arst_n && in_valid && sensor_if.ready;
		if (sensor_taken) begin
			expected_wheels.push_back(predict_wheels(in_bits));
			sensors_accepted++;
		end
		if (arst_n && wheel_if.valid && out_ready) begin
			got = wheel_if.payload;
			wheels_checked++;
			if (expected_wheels.size() == 0) begin
				$display("%0t: unexpected wheel request left=%0d right=%0d error=%0d",
					$time, got.left_drive, got.right_drive, got.error_out);
				mismatches++;
			end else begin
				want = expected_wheels.pop_front();
				if (got.left_drive !== want.left_drive) begin
					$display("%0t: left_drive expected %0d actual %0d",
						$time, want.left_drive, got.left_drive);
					mismatches++;
				end
				if (got.right_drive !== want.right_drive) begin
					$display("%0t: right_drive expected %0d actual %0d",
						$time, want.right_drive, got.right_drive);
					mismatches++;
				end
				if (got.error_out !== want.error_out) begin
					$display("%0t: error_out expected %0d actual %0d",
						$time, want.error_out, got.error_out);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("%0t: run limit of %0d cycles reached", $time, LIMIT_CYCLES);
			$display("line_follow_pid_steering verification failed");
			$finish;
		end
	end

	// One APB write: setup cycle, then access cycle until pready.
	task automatic write_reg(input lfps_pkg::reg_idx_t idx, input logic [63:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = ADDR_W'(int'(idx) * 8);
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			lfps_pkg::REG_GAIN_P:
				model_cfg.gain_p = value[lfps_pkg::GAIN_W-1:0];
			lfps_pkg::REG_GAIN_I:
				model_cfg.gain_i = value[lfps_pkg::GAIN_W-1:0];
			lfps_pkg::REG_GAIN_D:
				model_cfg.gain_d = value[lfps_pkg::GAIN_W-1:0];
			lfps_pkg::REG_NOMINAL_DRIVE:
				model_cfg.nominal_drive = value[lfps_pkg::SPEED_W-1:0];
			lfps_pkg::REG_DRIVE_CAP:
				model_cfg.drive_cap = value[lfps_pkg::SPEED_W-1:0];
			lfps_pkg::REG_STEER_LIMIT:
				model_cfg.steer_limit = value[lfps_pkg::SPEED_W-1:0];
			lfps_pkg::REG_INTEG_LIMITS:
				model_cfg.integral_limits = value[lfps_pkg::LIMIT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic apply_settings(input lfps_pkg::cfg_t s);
		write_reg(lfps_pkg::REG_GAIN_P, 64'(s.gain_p));
		write_reg(lfps_pkg::REG_GAIN_I, 64'(s.gain_i));
		write_reg(lfps_pkg::REG_GAIN_D, 64'(s.gain_d));
		write_reg(lfps_pkg::REG_NOMINAL_DRIVE, 64'(s.nominal_drive));
		write_reg(lfps_pkg::REG_DRIVE_CAP, 64'(s.drive_cap));
		write_reg(lfps_pkg::REG_STEER_LIMIT, 64'(s.steer_limit));
		write_reg(lfps_pkg::REG_INTEG_LIMITS, 64'(s.integral_limits));
		settings_used++;
	endtask

	// Waits until every mask has gone in and every wheel request has come out.
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_masks.size() != 0 || in_valid || expected_wheels.size() != 0);
	endtask

	// Random settings; integral limits are mostly small so the clamps bite.
	function automatic lfps_pkg::cfg_t random_settings();
		lfps_pkg::cfg_t s;
		s.gain_p = lfps_pkg::GAIN_W'($urandom);
		s.gain_i = ($urandom_range(0, 1) == 0) ? lfps_pkg::GAIN_W'($urandom_range(0, 64))
			: lfps_pkg::GAIN_W'($urandom);
		s.gain_d = lfps_pkg::GAIN_W'($urandom);
		s.nominal_drive = lfps_pkg::SPEED_W'($urandom);
		s.drive_cap = ($urandom_range(0, 2) == 0) ? lfps_pkg::SPEED_W'($urandom)
			: s.nominal_drive + lfps_pkg::SPEED_W'($urandom_range(0, 2000));
		s.steer_limit = ($urandom_range(0, 1) == 0) ? lfps_pkg::SPEED_W'($urandom)
			: lfps_pkg::SPEED_W'($urandom_range(0, 3000));
		s.integral_limits[47:32] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
			: 16'($urandom_range(0, 300));
		s.integral_limits[31:16] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
			: 16'($urandom_range(0, 200));
		s.integral_limits[15:0] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
			: 16'($urandom_range(0, 100));
		return s;
	endfunction

	initial begin
		lfps_pkg::cfg_t s;
		logic [7:0]     mask;
		int             phase;
		int             n;
		int             side;
		int             run_left;
		logic [7:0]     lead_masks [4] = '{8'h00, 8'hFF, 8'h01, 8'h80};
		logic [7:0]     edge_masks [26] = '{
			8'h00, 8'h01, 8'h00, 8'h03, 8'h80, 8'hC0, 8'h60, 8'hE0, 8'h18,
			8'h3A, 8'h00, 8'h10, 8'h08, 8'h06, 8'h0C, 8'h30, 8'h7F, 8'hFE,
			8'h1F, 8'hF8, 8'h3F, 8'h7E, 8'hBA, 8'h5D, 8'hFD, 8'hFF
		};

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// A few requests under the reset settings, where every gain is zero.
		@(posedge clk);
		foreach (lead_masks[i]) begin
			pending_masks.push_back(lead_masks[i]);
		end
		wait_idle();

		// Directed requests: lost line, both ends, threshold edges, deadband
		// edges, rounding and side swings.
		s.gain_p = 16'h0200;
		s.gain_i = 16'h0010;
		s.gain_d = 16'h0100;
		s.nominal_drive = 15'd1000;
		s.drive_cap = 15'd2000;
		s.steer_limit = 15'd800;
		s.integral_limits = {16'd2000, 16'd1000, 16'd500};
		apply_settings(s);
		@(posedge clk);
		foreach (edge_masks[i]) begin
			pending_masks.push_back(edge_masks[i]);
		end
		wait_idle();

		// Random phases: half of the runs stay on one side of the line so the integral
		// builds up, the rest lost-line and arbitrary masks.
		run_left = 0;
		side = 0;
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				1: begin
					s.gain_p = '1;
					s.gain_i = '1;
					s.gain_d = '1;
					s.nominal_drive = '1;
					s.drive_cap = '1;
					s.steer_limit = '1;
					s.integral_limits = '1;
				end
				3: begin
					s = random_settings();
					s.gain_p = '1;
					s.nominal_drive = '0;
					s.steer_limit = '0;
					s.integral_limits = '0;
				end
				default: s = random_settings();
			endcase
			apply_settings(s);
			idling_on = (phase != 2 && phase != 5);
			@(posedge clk);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (run_left == 0) begin
					run_left = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(5, 60);
					side = $urandom_range(0, 3);
				end
				run_left--;
				case (side)
					0: mask = {4'b0000, 4'($urandom_range(1, 15))};
					1: mask = {4'($urandom_range(1, 15)), 4'b0000};
					2: mask = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
					default: mask = 8'($urandom);
				endcase
				if (side < 2 && $urandom_range(0, 7) == 0) begin
					mask = 8'h00;
				end
				pending_masks.push_back(mask);
			end
			wait_idle();
		end

		// Let any stray wheel request show up before closing.
		repeat (40) @(posedge clk);
		$display("Checked %0d wheel requests from %0d sensor requests under %0d settings,",
			wheels_checked, sensors_accepted, settings_used);
		$display("with lost-line runs, deadband and limit edges and a long output hold-off.");
		if (mismatches == 0 && expected_wheels.size() == 0) begin
			$display("line_follow_pid_steering verification clean");
		end else begin
			$display("line_follow_pid_steering verification failed");
		end
		$finish;
	end

endmodule
